### src/tppmd_pkg.sv
`default_nettype none

package tppmd_pkg;

  localparam int DRIVE_LIMIT       = 1024;
  localparam int FULL_ON_THRESHOLD = 900;
  localparam logic [9:0] MAG_MAX   = 10'h3FF;

  typedef enum logic [2:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_DERIV_GAIN   = 3'd1,
    REG_ERROR_LIMIT  = 3'd2,
    REG_ACCEL_STEP   = 3'd3,
    REG_COAST_SPEED  = 3'd4,
    REG_DECEL_POINT  = 3'd5,
    REG_PROFILE_BASE = 3'd6,
    REG_MOVE_TARGET  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] deriv_gain;
    logic [14:0]        error_limit;
    logic [31:0]        accel_step;
    logic [31:0]        coast_speed;
    logic [31:0]        decel_point;
    logic signed [31:0] profile_base;
    logic signed [31:0] move_target;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] measured_position;
    logic               move_negative;
    logic               follow_mode;
    logic               speed_mode;
    logic               speed_target_valid;
    logic [31:0]        speed_target;
    logic               power_off;
  } tick_t;

  typedef struct packed {
    logic signed [15:0] err;
    logic signed [16:0] delta;
    logic signed [31:0] set_point;
    logic [31:0]        speed;
    logic               moving;
    logic               fault;
    logic               ramp;
    logic               power_off;
  } err_word_t;

endpackage

`default_nettype wire

### src/trapezoid_profile_pd_motor_drive.sv
// Trapezoidal-profile PD position drive. One input word is one control tick; each
// tick gives one result word. Words pass an input register, the profile and
// error stage (which holds all profile state) and the PD / PWM output register,
// in that order, and a new tick is taken
// every cycle while the output side keeps up. Ready follows out_ready through
// the whole pipeline. Configuration writes take effect at once and belong to
// idle periods only.

`default_nettype none

module trapezoid_profile_pd_motor_drive
  import tppmd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               action,
  input  wire logic signed [31:0] measured_position,
  input  wire logic               move_negative,
  input  wire logic               follow_mode,
  input  wire logic               speed_mode,
  input  wire logic               speed_target_valid,
  input  wire logic [31:0]        speed_target,
  input  wire logic               power_off,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    drive_forward,
  output logic                    drive_reverse,
  output logic [7:0]              pwm_duty_byte,
  output logic signed [31:0]      set_point,
  output logic [31:0]             current_speed,
  output logic                    move_active,
  output logic                    motion_fault,
  output logic                    ramping
);

  cfg_t      cfg;
  tick_t     tick;
  err_word_t word;
  logic      adv;
  logic      s1_vld;
  logic      s2_vld;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{prop_gain: '0, deriv_gain: '0, error_limit: 15'h7FFF, accel_step: '0,
               coast_speed: '0, decel_point: '0, profile_base: '0, move_target: '0};
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_PROP_GAIN:    cfg.prop_gain    <= cfg_data[15:0];
        REG_DERIV_GAIN:   cfg.deriv_gain   <= cfg_data[15:0];
        REG_ERROR_LIMIT:  cfg.error_limit  <= cfg_data[14:0];
        REG_ACCEL_STEP:   cfg.accel_step   <= cfg_data;
        REG_COAST_SPEED:  cfg.coast_speed  <= cfg_data;
        REG_DECEL_POINT:  cfg.decel_point  <= cfg_data;
        REG_PROFILE_BASE: cfg.profile_base <= cfg_data;
        REG_MOVE_TARGET:  cfg.move_target  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_vld    <= in_valid;
      s2_vld    <= s1_vld;
      out_valid <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      tick <= '{action: action, measured_position: measured_position,
                move_negative: move_negative, follow_mode: follow_mode,
                speed_mode: speed_mode, speed_target_valid: speed_target_valid,
                speed_target: speed_target, power_off: power_off};
    end
  end

  tppmd_profile u_profile (
    .clk  (clk),
    .rst  (rst),
    .fire (adv && s1_vld),
    .tick (tick),
    .cfg  (cfg),
    .word (word)
  );

  tppmd_pd u_pd (
    .clk           (clk),
    .load          (adv && s2_vld),
    .word          (word),
    .cfg           (cfg),
    .drive_forward (drive_forward),
    .drive_reverse (drive_reverse),
    .pwm_duty_byte (pwm_duty_byte),
    .set_point     (set_point),
    .current_speed (current_speed),
    .move_active   (move_active),
    .motion_fault  (motion_fault),
    .ramping       (ramping)
  );

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_forward |-> !drive_reverse) else $error("both directions on");

  a_off_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_forward && !drive_reverse |-> pwm_duty_byte == 8'hFF)
    else $error("drive off with non-idle duty");

endmodule

`default_nettype wire

### src/tppmd_profile.sv
`default_nettype none

module tppmd_profile
  import tppmd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      fire,
  input  wire tick_t     tick,
  input  wire cfg_t      cfg,
  output err_word_t      word
);

  logic [31:0]        speed;
  logic [63:0]        acc;
  logic [31:0]        tcs;
  logic signed [31:0] sp;
  logic signed [15:0] prev_err;
  logic               moving;
  logic               fault;
  logic               ramp;

  logic [63:0]        acc0, acc_sum, acc_next;
  logic [31:0]        spd0, tcs0, tcs1, spd_next, ramped, dn, travel;
  logic [32:0]        up;
  logic               flt0, mov0, sp_branch, decel, end_move, hit;
  logic signed [31:0] place, sp_used;
  logic signed [32:0] err33, lim33, errc;
  logic signed [15:0] err16;
  logic signed [16:0] delta;

  always_comb begin
    acc0 = tick.action ? 64'd0 : acc;
    spd0 = tick.action ? 32'd0 : speed;
    flt0 = tick.action ? 1'b0 : fault;
    tcs0 = tick.action ? cfg.coast_speed : tcs;
    mov0 = tick.action | moving;
    sp_branch = !mov0 && !tick.follow_mode && tick.speed_mode;
    tcs1 = (sp_branch && tick.speed_target_valid) ? tick.speed_target : tcs0;

    up = {1'b0, spd0} + {1'b0, cfg.accel_step};
    dn = (spd0 > cfg.accel_step) ? spd0 - cfg.accel_step : 32'd0;
    if (spd0 < tcs1) begin
      ramped = (up > {1'b0, tcs1}) ? tcs1 : up[31:0];
    end else if (spd0 > tcs1) begin
      ramped = (dn < tcs1) ? tcs1 : dn;
    end else begin
      ramped = spd0;
    end

    decel    = acc0[55:24] > cfg.decel_point;
    end_move = mov0 && decel && (dn < cfg.accel_step);

    if (mov0) begin
      spd_next = decel ? (end_move ? 32'd0 : dn) : ramped;
    end else if (sp_branch) begin
      spd_next = ramped;
    end else begin
      spd_next = spd0;
    end

    acc_sum  = acc0 + {32'd0, spd_next};
    acc_next = (mov0 || sp_branch) ? acc_sum : acc0;
    travel   = acc_sum[55:24];
    place    = tick.move_negative ? cfg.profile_base - $signed(travel)
                                  : cfg.profile_base + $signed(travel);

    if (mov0) begin
      sp_used = end_move ? cfg.move_target : place;
    end else if (tick.follow_mode) begin
      sp_used = tick.measured_position;
    end else if (tick.speed_mode) begin
      sp_used = place;
    end else begin
      sp_used = sp;
    end

    err33 = {sp_used[31], sp_used} - {tick.measured_position[31], tick.measured_position};
    lim33 = $signed({18'd0, cfg.error_limit});
    hit   = 1'b1;
    if (err33 > lim33) begin
      errc = lim33;
    end else if (err33 < -lim33) begin
      errc = -lim33;
    end else begin
      errc = err33;
      hit  = 1'b0;
    end
    err16 = errc[15:0];
    delta = {err16[15], err16} - {prev_err[15], prev_err};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed    <= '0;
      acc      <= '0;
      tcs      <= '0;
      sp       <= '0;
      prev_err <= '0;
      moving   <= 1'b0;
      fault    <= 1'b0;
      ramp     <= 1'b0;
    end else if (fire) begin
      speed    <= spd_next;
      acc      <= acc_next;
      tcs      <= sp_branch ? tcs1 : tcs0;
      sp       <= tick.power_off ? tick.measured_position : sp_used;
      prev_err <= err16;
      moving   <= mov0 & ~end_move;
      fault    <= flt0 | hit;
      ramp     <= sp_branch ? (spd0 != tcs1) : ramp;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      word.err       <= err16;
      word.delta     <= delta;
      word.set_point <= sp_used;
      word.speed     <= spd_next;
      word.moving    <= mov0 & ~end_move;
      word.fault     <= flt0 | hit;
      word.ramp      <= sp_branch ? (spd0 != tcs1) : ramp;
      word.power_off <= tick.power_off;
    end
  end

  // a start always leaves a move running: distance is zero, never past decel_point
  a_start_moves: assert property (@(posedge clk) disable iff (rst)
    fire && tick.action |=> moving) else $error("move not running after start");

  a_no_spurious_move: assert property (@(posedge clk) disable iff (rst)
    !moving && !(fire && tick.action) |=> !moving)
    else $error("move began without a start");

  a_clamp_sets_fault: assert property (@(posedge clk) disable iff (rst)
    fire && hit |=> fault) else $error("clamped error without fault");

endmodule

`default_nettype wire

### src/tppmd_pd.sv
`default_nettype none

module tppmd_pd
  import tppmd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        load,
  input  wire err_word_t   word,
  input  wire cfg_t        cfg,
  output logic             drive_forward,
  output logic             drive_reverse,
  output logic [7:0]       pwm_duty_byte,
  output logic signed [31:0] set_point,
  output logic [31:0]      current_speed,
  output logic             move_active,
  output logic             motion_fault,
  output logic             ramping
);

  logic signed [31:0] p_term;
  logic signed [32:0] d_term;
  logic signed [33:0] sum;
  logic signed [16:0] sat;
  logic [16:0]        mag17;
  logic [9:0]         mag;
  logic [9:0]         inv;
  logic               fwd, rev;

  always_comb begin
    p_term = cfg.prop_gain * word.err;
    d_term = cfg.deriv_gain * word.delta;
    sum    = 34'(p_term) + 34'(d_term);
    if (sum > 34'sd32767) begin
      sat = 17'sd32767;
    end else if (sum < -34'sd32768) begin
      sat = -17'sd32768;
    end else begin
      sat = sum[16:0];
    end

    rev   = sat[16];
    fwd   = ~sat[16];
    mag17 = rev ? 17'(-sat) : 17'(sat);
    if (mag17 > 17'(DRIVE_LIMIT)) begin
      mag17 = 17'(DRIVE_LIMIT);
    end
    if (word.power_off) begin
      fwd   = 1'b0;
      rev   = 1'b0;
      mag17 = '0;
    end
    if (mag17 > 17'(FULL_ON_THRESHOLD) || mag17 > {7'd0, MAG_MAX}) begin
      mag = MAG_MAX;
    end else begin
      mag = mag17[9:0];
    end
    inv = MAG_MAX - mag;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_forward <= fwd;
      drive_reverse <= rev;
      pwm_duty_byte <= inv[9:2];
      set_point     <= word.set_point;
      current_speed <= word.speed;
      move_active   <= word.moving;
      motion_fault  <= word.fault;
      ramping       <= word.ramp;
    end
  end

endmodule

`default_nettype wire

### tb/drive_check_pkg.sv
`timescale 1ns / 1ps

package drive_check_pkg;
  import tppmd_pkg::*;

  typedef struct packed {
    logic               fwd;
    logic               rev;
    logic [7:0]         duty;
    logic signed [31:0] sp;
    logic [31:0]        speed;
    logic               active;
    logic               fault;
    logic               ramp;
  } drive_word_t;

  class pd_drive_tracker;
    logic signed [15:0] kp;
    logic signed [15:0] kd;
    logic [14:0]        err_lim;
    logic [31:0]        accel;
    logic [31:0]        coast;
    logic [31:0]        decel_at;
    logic [31:0]        origin;
    logic [31:0]        end_point;

    logic [31:0]        speed;
    logic [63:0]        travelled;
    logic [31:0]        coast_track;
    logic [31:0]        sp;
    longint             prev_err;
    bit                 moving;
    bit                 fault;
    bit                 ramp;

    drive_word_t        drive_due[$];
    int                 mismatches;

    function new();
      kp = '0;
      kd = '0;
      err_lim = 15'h7FFF;
      accel = '0;
      coast = '0;
      decel_at = '0;
      origin = '0;
      end_point = '0;
      speed = '0;
      travelled = '0;
      coast_track = '0;
      sp = '0;
      prev_err = 0;
      moving = 0;
      fault = 0;
      ramp = 0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [31:0] v);
      case (idx)
        REG_PROP_GAIN:    kp = v[15:0];
        REG_DERIV_GAIN:   kd = v[15:0];
        REG_ERROR_LIMIT:  err_lim = v[14:0];
        REG_ACCEL_STEP:   accel = v;
        REG_COAST_SPEED:  coast = v;
        REG_DECEL_POINT:  decel_at = v;
        REG_PROFILE_BASE: origin = v;
        REG_MOVE_TARGET:  end_point = v;
        default: ;
      endcase
    endfunction

    function logic [31:0] sub_floor(logic [31:0] a, logic [31:0] b);
      return (a > b) ? a - b : '0;
    endfunction

    function void ramp_to(logic [31:0] goal);
      logic [32:0] up;
      logic [31:0] dn;
      if (speed < goal) begin
        up = {1'b0, speed} + {1'b0, accel};
        speed = (up > {1'b0, goal}) ? goal : up[31:0];
      end else if (speed > goal) begin
        dn = sub_floor(speed, accel);
        speed = (dn < goal) ? goal : dn;
      end
    endfunction

    function void advance(bit neg);
      logic [31:0] travel;
      travelled = travelled + {32'b0, speed};
      travel = travelled[55:24];
      sp = neg ? origin - travel : origin + travel;
    endfunction

    function void take_tick(tick_t t);
      drive_word_t r;
      logic [31:0] used;
      longint err;
      longint lim;
      longint delta;
      longint sum;
      int mag;
      if (t.action) begin
        travelled = '0;
        speed = '0;
        fault = 0;
        coast_track = coast;
        moving = 1;
      end
      if (moving) begin
        if (travelled[55:24] > decel_at) begin
          speed = sub_floor(speed, accel);
          if (speed < accel) begin
            sp = end_point;
            speed = '0;
            moving = 0;
          end
        end else begin
          ramp_to(coast_track);
        end
        if (moving) advance(t.move_negative);
      end else if (t.follow_mode) begin
        sp = t.measured_position;
      end else if (t.speed_mode) begin
        if (t.speed_target_valid) coast_track = t.speed_target;
        ramp = (speed != coast_track);
        ramp_to(coast_track);
        advance(t.move_negative);
      end

      used = sp;
      err = longint'($signed(used)) - longint'($signed(t.measured_position));
      lim = longint'(err_lim);
      if (err > lim) begin
        err = lim;
        fault = 1;
      end else if (err < -lim) begin
        err = -lim;
        fault = 1;
      end
      delta = err - prev_err;
      prev_err = err;

      sum = longint'(kp) * err + longint'(kd) * delta;
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      r.fwd = (sum >= 0);
      r.rev = (sum < 0);
      if (sum < 0) sum = -sum;
      if (sum > DRIVE_LIMIT) sum = DRIVE_LIMIT;
      mag = int'(sum);

      if (t.power_off) begin
        r.fwd = 0;
        r.rev = 0;
        mag = 0;
        sp = t.measured_position;
      end
      if (mag > FULL_ON_THRESHOLD) mag = int'(MAG_MAX);
      r.duty = 8'((int'(MAG_MAX) - mag) >> 2);
      r.sp = used;
      r.speed = speed;
      r.active = moving;
      r.fault = fault;
      r.ramp = ramp;
      drive_due.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void match_drive(drive_word_t got);
      drive_word_t want;
      if (drive_due.size() == 0) begin
        $error("drive word with nothing pending");
        mismatches++;
        return;
      end
      want = drive_due.pop_front();
      compare("drive_forward", 32'(want.fwd), 32'(got.fwd));
      compare("drive_reverse", 32'(want.rev), 32'(got.rev));
      compare("pwm_duty_byte", 32'(want.duty), 32'(got.duty));
      compare("set_point", want.sp, got.sp);
      compare("current_speed", want.speed, got.speed);
      compare("move_active", 32'(want.active), 32'(got.active));
      compare("motion_fault", 32'(want.fault), 32'(got.fault));
      compare("ramping", 32'(want.ramp), 32'(got.ramp));
    endfunction
  endclass

endpackage

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import tppmd_pkg::*;
  import drive_check_pkg::*;

  localparam int PHASES          = 12;
  localparam int TICKS_PER_PHASE = 90;
  localparam int HOLD_CYCLES     = 64;
  localparam int WATCHDOG_LIMIT  = 1000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  tick_t              cur_tick = '0;
  logic               out_ready = 1'b0;

  logic               in_ready;
  logic               out_valid;
  logic               drive_forward;
  logic               drive_reverse;
  logic [7:0]         pwm_duty_byte;
  logic signed [31:0] set_point;
  logic [31:0]        current_speed;
  logic               move_active;
  logic               motion_fault;
  logic               ramping;

  pd_drive_tracker    tracker;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  bit                 hold_req = 0;
  bit                 move_dir = 0;
  int                 stall_run = 0;

  always #2 clk = ~clk;

  trapezoid_profile_pd_motor_drive DUT (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .action             (cur_tick.action),
    .measured_position  (cur_tick.measured_position),
    .move_negative      (cur_tick.move_negative),
    .follow_mode        (cur_tick.follow_mode),
    .speed_mode         (cur_tick.speed_mode),
    .speed_target_valid (cur_tick.speed_target_valid),
    .speed_target       (cur_tick.speed_target),
    .power_off          (cur_tick.power_off),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .drive_forward      (drive_forward),
    .drive_reverse      (drive_reverse),
    .pwm_duty_byte      (pwm_duty_byte),
    .set_point          (set_point),
    .current_speed      (current_speed),
    .move_active        (move_active),
    .motion_fault       (motion_fault),
    .ramping            (ramping)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.take_tick(cur_tick);
      if (out_valid && out_ready)
        tracker.match_drive(drive_word_t'{drive_forward, drive_reverse, pwm_duty_byte,
                                          set_point, current_speed, move_active,
                                          motion_fault, ramping});
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_run <= 0;
    end else if (stall_run >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      stall_run <= stall_run + 1;
    end
  end

  // receiver; a hold request keeps ready low for a long stretch
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cur_tick <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    tracker.write_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_PROP_GAIN, 32'(c.prop_gain));
    write_reg(REG_DERIV_GAIN, 32'(c.deriv_gain));
    write_reg(REG_ERROR_LIMIT, 32'(c.error_limit));
    write_reg(REG_ACCEL_STEP, c.accel_step);
    write_reg(REG_COAST_SPEED, c.coast_speed);
    write_reg(REG_DECEL_POINT, c.decel_point);
    write_reg(REG_PROFILE_BASE, c.profile_base);
    write_reg(REG_MOVE_TARGET, c.move_target);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.drive_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic tick_t mk_tick(bit act, logic [31:0] meas, bit neg, bit fol, bit spm,
                                    bit tv, logic [31:0] tgt, bit poff);
    return tick_t'{act, meas, neg, fol, spm, tv, tgt, poff};
  endfunction

  function automatic cfg_t rand_cfg(int phase);
    cfg_t c;
    case ($urandom_range(0, 7))
      0: c.prop_gain = 16'sh8000;
      1: c.prop_gain = 16'sh7FFF;
      2: c.prop_gain = 16'($urandom);
      default: c.prop_gain = 16'(int'($urandom_range(0, 80)) - 40);
    endcase
    case ($urandom_range(0, 7))
      0: c.deriv_gain = 16'sh8000;
      1: c.deriv_gain = 16'sh7FFF;
      2: c.deriv_gain = 16'($urandom);
      default: c.deriv_gain = 16'(int'($urandom_range(0, 80)) - 40);
    endcase
    case ($urandom_range(0, 7))
      0: c.error_limit = '0;
      1: c.error_limit = '1;
      2: c.error_limit = 15'($urandom);
      default: c.error_limit = 15'($urandom_range(1, 3000));
    endcase
    c.accel_step = $urandom_range(32'h0010_0000, 32'h0080_0000);
    c.coast_speed = c.accel_step * $urandom_range(2, 30);
    c.decel_point = $urandom_range(0, 200);
    case ($urandom_range(0, 9))
      0: c.accel_step = '0;
      1: c.accel_step = '1;
      2: c.accel_step = $urandom;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: c.coast_speed = '0;
      1: c.coast_speed = '1;
      2: c.coast_speed = $urandom;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: c.decel_point = '0;
      1: c.decel_point = '1;
      2: c.decel_point = $urandom;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: c.profile_base = 32'sh8000_0000;
      1: c.profile_base = 32'sh7FFF_FFFF;
      default: c.profile_base = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0: c.move_target = 32'sh8000_0000;
      1: c.move_target = 32'sh7FFF_FFFF;
      default: c.move_target = $urandom;
    endcase
    if (phase == 2)
      c = '{prop_gain: 16'sh7FFF, deriv_gain: 16'sh7FFF, error_limit: '1, accel_step: '1,
            coast_speed: '1, decel_point: '1, profile_base: 32'sh7FFF_FFFF,
            move_target: 32'sh7FFF_FFFF};
    if (phase == 6)
      c = '{prop_gain: 16'sh8000, deriv_gain: 16'sh8000, error_limit: '0, accel_step: '0,
            coast_speed: '0, decel_point: '0, profile_base: 32'sh8000_0000,
            move_target: 32'sh8000_0000};
    return c;
  endfunction

  // mostly ticks near the present set point, so the PD loop sees small errors
  function automatic tick_t gen_tick();
    tick_t t;
    t.action = tracker.moving ? ($urandom_range(99) < 1) : ($urandom_range(99) < 12);
    if (t.action) move_dir = 1'($urandom_range(1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t.measured_position = tracker.sp + 32'(int'($urandom_range(0, 16)) - 8);
      4, 5, 6:    t.measured_position = tracker.sp + 32'(int'($urandom_range(0, 4000)) - 2000);
      7:          t.measured_position = tracker.sp
                                        + 32'(int'($urandom_range(0, 200000)) - 100000);
      default:    t.measured_position = $urandom;
    endcase
    t.move_negative = ($urandom_range(9) == 0) ? !move_dir : move_dir;
    t.follow_mode = ($urandom_range(99) < 15);
    t.speed_mode = ($urandom_range(99) < 40);
    t.speed_target_valid = ($urandom_range(99) < 15);
    case ($urandom_range(0, 9))
      0:       t.speed_target = '0;
      1:       t.speed_target = '1;
      2, 3:    t.speed_target = $urandom;
      default: t.speed_target = $urandom_range(32'h0010_0000, 32'h0400_0000);
    endcase
    t.power_off = ($urandom_range(99) < 4);
    return t;
  endfunction

  initial begin
    tracker = new();
    send_idle_pct = 24;
    recv_idle_pct = 45;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apply_config('{prop_gain: 16'sh7FFF, deriv_gain: 16'sh8000, error_limit: '1,
                   accel_step: 32'h0040_0000, coast_speed: 32'h0500_0000, decel_point: 20,
                   profile_base: 32'sh7FFF_FFF0, move_target: -32'sd5});
    // error clamps both ways, power off, follow, speed mode up and down
    send_tick(mk_tick(0, 32'h8000_0000, 0, 0, 0, 0, '0, 0));
    send_tick(mk_tick(0, 32'h7FFF_FFFF, 0, 0, 0, 0, '0, 0));
    send_tick(mk_tick(0, 32'h0000_0000, 0, 0, 0, 0, '0, 1));
    send_tick(mk_tick(0, 32'd123, 0, 1, 0, 0, '0, 0));
    send_tick(mk_tick(0, 32'd120, 0, 0, 0, 0, '0, 0));
    send_tick(mk_tick(0, 32'd0, 0, 0, 1, 1, '1, 0));
    repeat (3) send_tick(mk_tick(0, 32'd0, 0, 0, 1, 0, '0, 0));
    send_tick(mk_tick(0, 32'd0, 1, 0, 1, 1, '0, 0));
    send_tick(mk_tick(0, 32'd0, 1, 0, 1, 0, '0, 0));
    // move wins over the mode bits; then a restart part way through
    send_tick(mk_tick(1, 32'd0, 1, 1, 1, 0, '0, 0));
    repeat (8) send_tick(mk_tick(0, 32'h7FFF_FFF0, 1, 0, 0, 0, '0, 0));
    send_tick(mk_tick(1, 32'd5, 0, 0, 0, 0, '0, 0));
    send_tick(mk_tick(0, 32'hFFFF_FFFF, 0, 0, 0, 0, '1, 1));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 4) ? 24 : ((p < 8) ? 45 : 0);
      recv_idle_pct = (p < 4) ? 45 : ((p < 8) ? 24 : 0);
      apply_config(rand_cfg(p));
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (n == 30 && (p == 1 || p == 5 || p == 9)) hold_req = 1;
        send_tick(gen_tick());
      end
      settle();
    end

    repeat (8) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.drive_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
